// ----- design/hufd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants of the Huffman tree loader and decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int unsigned NODE_ENTRIES_DEF  = 512;
    localparam int unsigned STACK_ENTRIES_DEF = 256;

    localparam int unsigned SYMBOL_BITS = 8;
    localparam int unsigned SYM_CNT_W   = 3;
    localparam logic [SYM_CNT_W-1:0] SYMBOL_LAST = SYM_CNT_W'(SYMBOL_BITS - 1);

    localparam int unsigned LEN_W = 24;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_TREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_PAYLOAD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SYMBOL = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bit_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   last_symbol;
    } t_out_item;

endpackage
`default_nettype wire

// ----- design/huffman_tree_load_and_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Rebuilds a byte-alphabet Huffman tree from preorder bits into a node store,
// then decodes payload bits by walking the tree one bit per item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_item (op, bit)
//  out      | output    | o_out_valid / i_out_stall | o_out_item
//  cfg      | input     | i_cfg_we                  | i_cfg_wdata (length)
//
//  tree bits and clears are taken one per cycle unless the input is stalled;
//  a payload bit stalls it until its child entry is read from the node store.
//  one result register sits on the output; items are taken while it drains.
//  synchronous active-low reset clears control state only; no clearing pass.
//  the top of the pending stack is read continuously, ready well before a pop.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode #(
    parameter int unsigned NODE_ENTRIES  = hufd_pkg::NODE_ENTRIES_DEF,
    parameter int unsigned STACK_ENTRIES = hufd_pkg::STACK_ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire hufd_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output hufd_pkg::t_out_item              o_out_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [hufd_pkg::LEN_W-1:0]  i_cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(NODE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(NODE_ENTRIES + 1);
    localparam int unsigned SA_W  = $clog2(STACK_ENTRIES);
    localparam int unsigned SD_W  = $clog2(STACK_ENTRIES + 1);
    localparam int unsigned SYM_W = hufd_pkg::SYMBOL_BITS;
    localparam int unsigned LW    = (IDX_W > SYM_W) ? IDX_W : SYM_W;
    localparam int unsigned LEN_W = hufd_pkg::LEN_W;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_SYM  = 2'd1;
    localparam logic [1:0] PH_WALK = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    // control state
    logic [LEN_W-1:0]              r_len, n_len;
    logic [1:0]                    r_phase, n_phase;
    logic [CNT_W-1:0]              r_node_count, n_node_count;
    logic [SD_W-1:0]               r_depth, n_depth;
    logic [IDX_W-1:0]              r_att_parent, n_att_parent;
    logic                          r_att_right, n_att_right;
    logic [hufd_pkg::SYM_CNT_W-1:0] r_bits_seen, n_bits_seen;
    logic [SYM_W-1:0]              r_shift, n_shift;
    logic                          r_at_root, n_at_root;
    logic [LEN_W-1:0]              r_emitted, n_emitted;
    logic                          r_pend, n_pend;
    logic                          r_out_valid, n_out_valid;

    // payload state
    logic                          r_cur_leaf, n_cur_leaf;
    logic [LW-1:0]                 r_cur_left, n_cur_left;
    logic [IDX_W-1:0]              r_cur_right, n_cur_right;
    logic                          r_root_leaf, n_root_leaf;
    logic [LW-1:0]                 r_root_left, n_root_left;
    logic [IDX_W-1:0]              r_root_right, n_root_right;
    logic                          r_pend_leaf, n_pend_leaf;
    logic [SYM_W-1:0]              r_pend_sym, n_pend_sym;
    hufd_pkg::t_out_item           r_out_item, n_out_item;

    // memory ports
    logic             left_we, right_we, rd_en, stk_we;
    logic [IDX_W-1:0] left_addr, right_addr, rd_addr;
    logic [LW:0]      left_wdata, rd_left;
    logic [IDX_W-1:0] right_wdata, rd_right;
    logic [SA_W-1:0]  stk_waddr, stk_raddr;
    logic [IDX_W-1:0] stk_wdata, stk_rdata;

    logic             out_free, accept, complete;
    logic             cur_leaf;
    logic [LW-1:0]    cur_left;
    logic [IDX_W-1:0] cur_right;
    logic [IDX_W-1:0] new_idx, leaf_idx;
    logic [SYM_W-1:0] shift_nx;
    logic [LEN_W-1:0] count_nx;
    logic             last;

    hufd_node_ram #(
        .DEPTH   (NODE_ENTRIES),
        .LEFT_W  (LW),
        .RIGHT_W (IDX_W)
    ) u_node_ram (
        .i_clk         (i_clk),
        .i_left_we     (left_we),
        .i_left_addr   (left_addr),
        .i_left_wdata  (left_wdata),
        .i_right_we    (right_we),
        .i_right_addr  (right_addr),
        .i_right_wdata (right_wdata),
        .i_rd_en       (rd_en),
        .i_rd_addr     (rd_addr),
        .o_rd_left     (rd_left),
        .o_rd_right    (rd_right)
    );

    hufd_stack_ram #(
        .DEPTH  (STACK_ENTRIES),
        .DATA_W (IDX_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign complete   = r_pend && out_free;

    // the walk position is either the root, held in shadow registers, or a copy
    // of the last inner node read
    assign cur_leaf  = r_at_root ? r_root_leaf  : r_cur_leaf;
    assign cur_left  = r_at_root ? r_root_left  : r_cur_left;
    assign cur_right = r_at_root ? r_root_right : r_cur_right;

    assign new_idx   = r_node_count[IDX_W-1:0];
    assign leaf_idx  = IDX_W'(r_node_count - CNT_W'(1));
    assign shift_nx  = {r_shift[SYM_W-2:0], i_in_item.bit_value};
    assign count_nx  = r_emitted + LEN_W'(1);
    assign last      = (count_nx == r_len);
    assign stk_raddr = SA_W'(r_depth - SD_W'(1));

    always_comb begin
        n_len        = r_len;
        n_phase      = r_phase;
        n_node_count = r_node_count;
        n_depth      = r_depth;
        n_att_parent = r_att_parent;
        n_att_right  = r_att_right;
        n_bits_seen  = r_bits_seen;
        n_shift      = r_shift;
        n_at_root    = r_at_root;
        n_emitted    = r_emitted;
        n_pend       = r_pend;
        n_cur_leaf   = r_cur_leaf;
        n_cur_left   = r_cur_left;
        n_cur_right  = r_cur_right;
        n_root_leaf  = r_root_leaf;
        n_root_left  = r_root_left;
        n_root_right = r_root_right;
        n_pend_leaf  = r_pend_leaf;
        n_pend_sym   = r_pend_sym;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;

        left_we     = 1'b0;
        left_addr   = new_idx;
        left_wdata  = '0;
        right_we    = 1'b0;
        right_addr  = r_att_parent;
        right_wdata = new_idx;
        rd_en       = 1'b0;
        rd_addr     = '0;
        stk_we      = 1'b0;
        stk_waddr   = r_depth[SA_W-1:0];
        stk_wdata   = new_idx;

        if (i_cfg_we) begin
            n_len = i_cfg_wdata;
        end

        priority if (complete) begin
            n_pend = 1'b0;
            if (r_pend_leaf || rd_left[LW]) begin
                n_emitted   = count_nx;
                n_at_root   = 1'b1;
                n_out_valid = 1'b1;
                n_out_item.status      = hufd_pkg::ST_SYMBOL;
                n_out_item.symbol      = r_pend_leaf ? r_pend_sym : rd_left[SYM_W-1:0];
                n_out_item.last_symbol = last;
                if (last) begin
                    n_phase = PH_HALT;
                end
            end else begin
                n_at_root   = 1'b0;
                n_cur_leaf  = rd_left[LW];
                n_cur_left  = rd_left[LW-1:0];
                n_cur_right = rd_right;
            end
        end else if (accept) begin
            n_out_item.status      = hufd_pkg::ST_ERROR;
            n_out_item.symbol      = '0;
            n_out_item.last_symbol = 1'b0;
            priority if (i_in_item.op == hufd_pkg::OP_CLEAR) begin
                n_phase      = PH_FLAG;
                n_node_count = '0;
                n_depth      = '0;
                n_att_parent = '0;
                n_att_right  = 1'b0;
                n_bits_seen  = '0;
                n_shift      = '0;
                n_at_root    = 1'b1;
                n_emitted    = '0;
            end else if (r_phase == PH_HALT) begin
                n_out_valid = 1'b1;
            end else if (i_in_item.op == hufd_pkg::OP_TREE && r_phase == PH_FLAG) begin
                if (r_node_count == CNT_W'(NODE_ENTRIES) ||
                    (i_in_item.bit_value && r_depth == SD_W'(STACK_ENTRIES))) begin
                    n_phase     = PH_HALT;
                    n_out_valid = 1'b1;
                end else begin
                    // a left link is implicit: the node after an inner node is its
                    // left child, so only right links touch the parent
                    if (r_node_count != '0 && r_att_right) begin
                        right_we = 1'b1;
                        if (r_att_parent == '0) begin
                            n_root_right = new_idx;
                        end
                    end
                    if (i_in_item.bit_value) begin
                        left_we    = 1'b1;
                        left_wdata = {1'b0, LW'(IDX_W'(new_idx + IDX_W'(1)))};
                        if (new_idx == '0) begin
                            n_root_leaf = 1'b0;
                            n_root_left = LW'(IDX_W'(new_idx + IDX_W'(1)));
                        end
                        stk_we       = 1'b1;
                        n_depth      = r_depth + SD_W'(1);
                        n_att_parent = new_idx;
                        n_att_right  = 1'b0;
                    end else begin
                        n_phase     = PH_SYM;
                        n_bits_seen = '0;
                        n_shift     = '0;
                    end
                    n_node_count = r_node_count + CNT_W'(1);
                end
            end else if (i_in_item.op == hufd_pkg::OP_TREE && r_phase == PH_SYM) begin
                n_shift = shift_nx;
                if (r_bits_seen != hufd_pkg::SYMBOL_LAST) begin
                    n_bits_seen = r_bits_seen + hufd_pkg::SYM_CNT_W'(1);
                end else begin
                    n_bits_seen = '0;
                    left_we     = 1'b1;
                    left_addr   = leaf_idx;
                    left_wdata  = {1'b1, LW'(shift_nx)};
                    if (leaf_idx == '0) begin
                        n_root_leaf = 1'b1;
                        n_root_left = LW'(shift_nx);
                    end
                    if (r_depth == '0) begin
                        n_phase     = PH_WALK;
                        n_at_root   = 1'b1;
                        n_emitted   = '0;
                        n_out_valid = 1'b1;
                        n_out_item.status = hufd_pkg::ST_TREE;
                    end else begin
                        n_depth      = r_depth - SD_W'(1);
                        n_att_parent = stk_rdata;
                        n_att_right  = 1'b1;
                        n_phase      = PH_FLAG;
                    end
                end
            end else if (i_in_item.op == hufd_pkg::OP_PAYLOAD && r_phase == PH_WALK) begin
                rd_en       = 1'b1;
                rd_addr     = i_in_item.bit_value ? cur_right : cur_left[IDX_W-1:0];
                n_pend      = 1'b1;
                n_pend_leaf = cur_leaf;
                n_pend_sym  = cur_left[SYM_W-1:0];
            end else begin
                // misordered bit or unused op code
                n_out_valid = 1'b1;
            end
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= hufd_pkg::LEN_RESET;
            r_phase      <= PH_FLAG;
            r_node_count <= '0;
            r_depth      <= '0;
            r_att_parent <= '0;
            r_att_right  <= 1'b0;
            r_bits_seen  <= '0;
            r_shift      <= '0;
            r_at_root    <= 1'b1;
            r_emitted    <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_len        <= n_len;
            r_phase      <= n_phase;
            r_node_count <= n_node_count;
            r_depth      <= n_depth;
            r_att_parent <= n_att_parent;
            r_att_right  <= n_att_right;
            r_bits_seen  <= n_bits_seen;
            r_shift      <= n_shift;
            r_at_root    <= n_at_root;
            r_emitted    <= n_emitted;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_leaf   <= n_cur_leaf;
        r_cur_left   <= n_cur_left;
        r_cur_right  <= n_cur_right;
        r_root_leaf  <= n_root_leaf;
        r_root_left  <= n_root_left;
        r_root_right <= n_root_right;
        r_pend_leaf  <= n_pend_leaf;
        r_pend_sym   <= n_pend_sym;
        r_out_item   <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

// ----- design/hufd_node_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_node_ram
// Node store: leaf flag plus left child or symbol in one array, right child
// in a second, so a new node and a parent link can be written together.
// ----------------------------------------------------------------------------
module hufd_node_ram #(
    parameter int unsigned DEPTH   = hufd_pkg::NODE_ENTRIES_DEF,
    parameter int unsigned LEFT_W  = 9,
    parameter int unsigned RIGHT_W = 9,
    localparam int unsigned AW     = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_left_we,
    input  wire logic [AW-1:0]      i_left_addr,
    input  wire logic [LEFT_W:0]    i_left_wdata,
    input  wire logic               i_right_we,
    input  wire logic [AW-1:0]      i_right_addr,
    input  wire logic [RIGHT_W-1:0] i_right_wdata,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic [LEFT_W:0]         o_rd_left,
    output logic [RIGHT_W-1:0]      o_rd_right
);

    logic [LEFT_W:0]    r_left_mem  [DEPTH];
    logic [RIGHT_W-1:0] r_right_mem [DEPTH];
    logic [LEFT_W:0]    r_rd_left;
    logic [RIGHT_W-1:0] r_rd_right;

    always_ff @(posedge i_clk) begin
        if (i_left_we) begin
            r_left_mem[i_left_addr] <= i_left_wdata;
        end
        if (i_right_we) begin
            r_right_mem[i_right_addr] <= i_right_wdata;
        end
        if (i_rd_en) begin
            r_rd_left  <= r_left_mem[i_rd_addr];
            r_rd_right <= r_right_mem[i_rd_addr];
        end
    end

    assign o_rd_left  = r_rd_left;
    assign o_rd_right = r_rd_right;

endmodule
`default_nettype wire

// ----- design/hufd_stack_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hufd_stack_ram
// Stack of inner nodes still waiting for a right child; the top entry is
// read every cycle.
// ----------------------------------------------------------------------------
module hufd_stack_ram #(
    parameter int unsigned DEPTH  = hufd_pkg::STACK_ENTRIES_DEF,
    parameter int unsigned DATA_W = 9,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0]      o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
